[hdl/mcw_pkg.sv]
// Shared types and constants of the minimum covering window unit.
`default_nettype none

package mcw_pkg;

  // Source positions and queue depth.
  localparam int unsigned MaxLen    = 4096;
  localparam int unsigned PosW      = 12;
  localparam int unsigned TailW     = 13;
  localparam int unsigned LenW      = 13;

  // Symbol alphabet.
  localparam int unsigned Alphabet  = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned SymCount  = 60;
  localparam logic [7:0]  FirstSym  = 8'd65;

  // Count widths; a need count can run past the missing limit by the have count.
  localparam int unsigned NeedW     = 14;
  localparam int unsigned HaveW     = 13;
  localparam int unsigned MissW     = 13;
  localparam logic [MissW-1:0] MissLimit = 13'd8191;

  // Input command codes.
  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdAdd   = 2'd1;
  localparam logic [1:0] CmdScan  = 2'd2;

  // Operation carried from the front to the back.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_SCAN  = 2'd2
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            is_sym;
    logic [IdxW-1:0] idx;
  } mcw_op_t;

  // Status of the back part, watched at the top level.
  typedef struct packed {
    logic [TailW-1:0] head;
    logic [TailW-1:0] tail;
    logic             shrinking;
    logic             missing_zero;
  } mcw_stat_t;

endpackage

`default_nettype wire

[hdl/minimum_covering_window_unit.sv]
// Top level of the minimum covering window unit.
//
// Input channel (in_valid_i, in_stall_o, command_i, symbol_i): command 0 clears
// all state, command 1 adds a target symbol, command 2 scans one source byte,
// command 3 does nothing. Only scan words give an output word (found_o,
// best_start_o, best_length_o, overflow_o) on the output channel.
// A front part classifies each word and puts those with an effect into a
// four-entry queue; the back part takes one word at a time from it. A clear is
// done in the idle state; a target add reads its counts, then writes them. A
// scan goes straight to the output for a non-symbol byte or once overflow is
// set; a match first reads its counts, and once the window covers the target
// the back part reads the head match from the queue and then its counts for
// each queued match it drops from the left of the window, as the count and
// match memories have registered reads. Each match is dropped at most once.
// Input words are still taken while the queue has room, also while a result
// waits in the output register. When the receiver stalls, the output word
// holds and the back part waits once its next result is ready.
// Reset clears the counts (through valid bits), pointers and flags at once;
// the match queue needs no clearing pass.
`default_nettype none

module minimum_covering_window_unit
  import mcw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       command_i,
  input  wire logic [7:0]       symbol_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  found_o,
  output logic [PosW-1:0]       best_start_o,
  output logic [LenW-1:0]       best_length_o,
  output logic                  overflow_o
);

  logic      push;
  logic      full;
  logic      op_valid;
  logic      op_pop;
  mcw_op_t   op_in;
  mcw_op_t   op_out;
  mcw_stat_t stat;

  mcw_front u_front (
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .symbol_i    (symbol_i),
    .fifo_full_i (full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .op_o        (op_in)
  );

  mcw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .pop_i   (op_pop),
    .full_o  (full),
    .valid_o (op_valid),
    .data_o  (op_out)
  );

  mcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_i          (op_out),
    .op_pop_o      (op_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .best_start_o  (best_start_o),
    .best_length_o (best_length_o),
    .overflow_o    (overflow_o),
    .stat_o        (stat)
  );

  // The window head never passes the tail.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat.head <= stat.tail)
    else $error("match queue head passed tail");

  // Shrinking only runs while the window covers the target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.shrinking |-> stat.missing_zero)
    else $error("window shrink while symbols missing");

  // A reported window always has a nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (best_length_o != '0))
    else $error("found window with zero length");

  // The queue is never pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("operation queue overrun");

endmodule

`default_nettype wire

[hdl/mcw_front.sv]
// Front part: accepts input words, classifies them and drops those with no effect.
`default_nettype none

module mcw_front
  import mcw_pkg::*;
(
  input  wire logic       in_valid_i,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic       fifo_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output mcw_op_t         op_o
);

  logic       is_sym;
  logic       keep;
  logic [7:0] offs;

  // Alphabet test and index.
  assign offs   = symbol_i - FirstSym;
  assign is_sym = (symbol_i >= FirstSym) && (offs < 8'(SymCount));

  // Classify the word; unused commands and non-symbol target adds are dropped.
  always_comb begin
    keep      = 1'b0;
    op_o.op   = OP_CLEAR;
    op_o.is_sym = is_sym;
    op_o.idx  = offs[IdxW-1:0];
    case (command_i)
      CmdClear: begin
        keep    = 1'b1;
        op_o.op = OP_CLEAR;
      end
      CmdAdd: begin
        keep    = is_sym;
        op_o.op = OP_ADD;
      end
      CmdScan: begin
        keep    = 1'b1;
        op_o.op = OP_SCAN;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i && keep;

endmodule

`default_nettype wire

[hdl/mcw_fifo.sv]
// Short queue of operations between the front and the back.
`default_nettype none

module mcw_fifo
  import mcw_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  mcw_op_t      data_i,
  input  wire logic    pop_i,
  output logic         full_o,
  output logic         valid_o,
  output mcw_op_t      data_o
);

  mcw_op_t    mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = do_push ? wr_q + 2'd1 : wr_q;
    rd_d  = do_pop ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {2'b00, do_push} - {2'b00, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/mcw_back.sv]
// Back part: count memories, match queue, window sequencer and result register.
`default_nettype none

module mcw_back
  import mcw_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            op_valid_i,
  input  mcw_op_t              op_i,
  output logic                 op_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 found_o,
  output logic [PosW-1:0]      best_start_o,
  output logic [LenW-1:0]      best_length_o,
  output logic                 overflow_o,
  output mcw_stat_t            stat_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADD  = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_SHRD = 7'b0001000,
    S_SHQ  = 7'b0010000,
    S_SHC  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Window state.
  logic [MissW-1:0] miss_q, miss_d;
  logic [TailW-1:0] head_q, head_d;
  logic [TailW-1:0] tail_q, tail_d;
  logic [TailW-1:0] scan_q, scan_d;
  logic [PosW-1:0]  bstart_q, bstart_d;
  logic [LenW-1:0]  blen_q, blen_d;
  logic             found_q, found_d;
  logic             ovf_q, ovf_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic             clear;

  // Count memories with per-entry valid bits; an invalid entry reads zero.
  logic [NeedW-1:0] need_mem [Alphabet];
  logic [HaveW-1:0] have_mem [Alphabet];
  logic [Alphabet-1:0] need_vld_q, have_vld_q;
  logic [NeedW-1:0] need_rd_q;
  logic [HaveW-1:0] have_rd_q;
  logic             need_rv_q, have_rv_q;
  logic [NeedW-1:0] need_v;
  logic [HaveW-1:0] have_v;
  logic [IdxW-1:0]  c_raddr;
  logic             need_we, have_we;
  logic [IdxW-1:0]  c_waddr;
  logic [NeedW-1:0] need_wdata;
  logic [HaveW-1:0] have_wdata;

  // Match queue memory.
  logic [PosW-1:0]  qpos_mem [MaxLen];
  logic [IdxW-1:0]  qsym_mem [MaxLen];
  logic             q_we, q_re;
  logic [PosW-1:0]  qpos_rd_q;
  logic [IdxW-1:0]  qsym_rd_q;

  // Result register.
  logic             out_vld_q;
  logic             load_out;
  logic             r_found_q, r_ovf_q;
  logic [PosW-1:0]  r_start_q;
  logic [LenW-1:0]  r_len_q;

  logic [LenW-1:0]  win_len;
  logic [HaveW-1:0] have_inc;

  assign need_v   = need_rv_q ? need_rd_q : '0;
  assign have_v   = have_rv_q ? have_rd_q : '0;
  assign have_inc = have_v + 1'b1;
  assign win_len  = {1'b0, pos_q} - {1'b0, qpos_rd_q} + 1'b1;
  assign load_out = (state_q == S_EMIT) && (!out_vld_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    miss_d     = miss_q;
    head_d     = head_q;
    tail_d     = tail_q;
    scan_d     = scan_q;
    bstart_d   = bstart_q;
    blen_d     = blen_q;
    found_d    = found_q;
    ovf_d      = ovf_q;
    pos_d      = pos_q;
    cur_d      = cur_q;
    clear      = 1'b0;
    op_pop_o   = 1'b0;
    c_raddr    = op_i.idx;
    c_waddr    = cur_q;
    need_we    = 1'b0;
    have_we    = 1'b0;
    need_wdata = need_v + 1'b1;
    have_wdata = have_inc;
    q_we       = 1'b0;
    q_re       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          cur_d    = op_i.idx;
          case (op_i.op)
            OP_CLEAR: begin
              clear    = 1'b1;
              miss_d   = '0;
              head_d   = '0;
              tail_d   = '0;
              scan_d   = '0;
              bstart_d = '0;
              blen_d   = '0;
              found_d  = 1'b0;
              ovf_d    = 1'b0;
            end
            OP_ADD: begin
              state_d = S_ADD;
            end
            OP_SCAN: begin
              if (ovf_q || scan_q >= TailW'(MaxLen)) begin
                ovf_d   = 1'b1;
                state_d = S_EMIT;
              end else begin
                pos_d   = scan_q[PosW-1:0];
                scan_d  = scan_q + 1'b1;
                state_d = op_i.is_sym ? S_SCAN : S_EMIT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ADD: begin
        if (!(miss_q >= MissLimit && NeedW'(have_v) <= need_v)) begin
          need_we = 1'b1;
          if (NeedW'(have_v) < need_v + 1'b1) begin
            miss_d = miss_q + 1'b1;
          end
        end
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (need_v == '0 || tail_q >= TailW'(MaxLen)) begin
          state_d = S_EMIT;
        end else begin
          q_we    = 1'b1;
          tail_d  = tail_q + 1'b1;
          have_we = 1'b1;
          if (NeedW'(have_inc) <= need_v && miss_q != '0) begin
            miss_d = miss_q - 1'b1;
          end
          state_d = (miss_d == '0) ? S_SHRD : S_EMIT;
        end
      end
      S_SHRD: begin
        if (head_q < tail_q) begin
          q_re    = 1'b1;
          state_d = S_SHQ;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SHQ: begin
        c_raddr = qsym_rd_q;
        state_d = S_SHC;
      end
      S_SHC: begin
        c_waddr = qsym_rd_q;
        if (NeedW'(have_v) > need_v) begin
          have_we    = 1'b1;
          have_wdata = have_v - 1'b1;
          head_d     = head_q + 1'b1;
          state_d    = S_SHRD;
        end else begin
          if (!found_q || win_len < blen_q) begin
            found_d  = 1'b1;
            bstart_d = qpos_rd_q;
            blen_d   = win_len;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      miss_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      scan_q   <= '0;
      bstart_q <= '0;
      blen_q   <= '0;
      found_q  <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      miss_q   <= miss_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      scan_q   <= scan_d;
      bstart_q <= bstart_d;
      blen_q   <= blen_d;
      found_q  <= found_d;
      ovf_q    <= ovf_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
  end

  // Valid bits of the count memories.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_vld_q <= '0;
      have_vld_q <= '0;
    end else if (clear) begin
      need_vld_q <= '0;
      have_vld_q <= '0;
    end else begin
      if (need_we) begin
        need_vld_q[c_waddr] <= 1'b1;
      end
      if (have_we) begin
        have_vld_q[c_waddr] <= 1'b1;
      end
    end
  end

  // Count memory arrays with registered read.
  always_ff @(posedge clk_i) begin
    if (need_we) begin
      need_mem[c_waddr] <= need_wdata;
    end
    if (have_we) begin
      have_mem[c_waddr] <= have_wdata;
    end
    need_rd_q <= need_mem[c_raddr];
    have_rd_q <= have_mem[c_raddr];
    need_rv_q <= need_vld_q[c_raddr];
    have_rv_q <= have_vld_q[c_raddr];
  end

  // Match queue with registered read of the head entry.
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qpos_mem[tail_q[PosW-1:0]] <= pos_q;
      qsym_mem[tail_q[PosW-1:0]] <= cur_q;
    end
    if (q_re) begin
      qpos_rd_q <= qpos_mem[head_q[PosW-1:0]];
      qsym_rd_q <= qsym_mem[head_q[PosW-1:0]];
    end
  end

  // Result register toward the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      r_found_q <= found_q;
      r_start_q <= bstart_q;
      r_len_q   <= blen_q;
      r_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign found_o       = r_found_q;
  assign best_start_o  = r_start_q;
  assign best_length_o = r_len_q;
  assign overflow_o    = r_ovf_q;

  assign stat_o.head         = head_q;
  assign stat_o.tail         = tail_q;
  assign stat_o.shrinking    = (state_q == S_SHRD) || (state_q == S_SHQ)
                               || (state_q == S_SHC);
  assign stat_o.missing_zero = (miss_q == '0);

endmodule

`default_nettype wire

[dv/mcw_window_checker.sv]
// Checker for the minimum covering window unit: watches both channels, predicts and compares.
`default_nettype none

module mcw_window_checker
  import mcw_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_i,
  input  wire logic [1:0]      command_i,
  input  wire logic [7:0]      symbol_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_stall_i,
  input  wire logic            found_i,
  input  wire logic [PosW-1:0] best_start_i,
  input  wire logic [LenW-1:0] best_length_i,
  input  wire logic            overflow_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   results_o
);

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] start;
    logic [LenW-1:0] len;
    logic            ovf;
  } window_t;

  // Predicted window state.
  int unsigned need_cnt [Alphabet];
  int unsigned have_cnt [Alphabet];
  int unsigned missing;
  int unsigned pos_q [MaxLen];
  int unsigned sym_q [MaxLen];
  int unsigned head;
  int unsigned tail;
  int unsigned scan_pos;
  window_t     best;
  window_t     expected_windows [$];
  int          err_cnt = 0;
  int          res_cnt = 0;

  assign pending_o = expected_windows.size();
  assign errors_o  = err_cnt;
  assign results_o = res_cnt;

  function automatic void clear_window();
    foreach (need_cnt[i]) begin
      need_cnt[i] = 0;
      have_cnt[i] = 0;
    end
    missing  = 0;
    head     = 0;
    tail     = 0;
    scan_pos = 0;
    best     = '0;
  endfunction

  function automatic bit sym_index(logic [7:0] b, output int unsigned idx);
    idx = b - FirstSym;
    return (b >= FirstSym) && (b < FirstSym + SymCount);
  endfunction

  function automatic void add_target(logic [7:0] b);
    int unsigned idx;
    if (!sym_index(b, idx)) return;
    if (missing >= MissLimit && have_cnt[idx] <= need_cnt[idx]) return;
    need_cnt[idx]++;
    if (have_cnt[idx] < need_cnt[idx]) missing++;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    int unsigned idx;
    int unsigned p;
    int unsigned s;
    p = scan_pos;
    scan_pos++;
    if (!sym_index(b, idx) || need_cnt[idx] == 0) return;
    if (tail >= MaxLen) return;
    pos_q[tail] = p;
    sym_q[tail] = idx;
    tail++;
    have_cnt[idx]++;
    if (have_cnt[idx] <= need_cnt[idx] && missing > 0) missing--;
    if (missing != 0) return;
    // Drop surplus matches from the left of the window.
    while (head < tail) begin
      s = sym_q[head];
      if (have_cnt[s] <= need_cnt[s]) break;
      have_cnt[s]--;
      head++;
    end
    if (head < tail) begin
      if (!best.found || (p - pos_q[head] + 1) < best.len) begin
        best.found = 1'b1;
        best.start = PosW'(pos_q[head]);
        best.len   = LenW'(p - pos_q[head] + 1);
      end
    end
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want, res_cnt);
    err_cnt++;
  endtask

  // Predict on each accepted input word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_window();
      expected_windows.delete();
    end else if (in_valid_i && !in_stall_i) begin
      case (command_i)
        CmdClear: clear_window();
        CmdAdd:   add_target(symbol_i);
        CmdScan: begin
          if (best.ovf || scan_pos >= MaxLen) best.ovf = 1'b1;
          else scan_byte(symbol_i);
          expected_windows.insert(expected_windows.size(), best);
        end
        default: ;
      endcase
    end
  end

  // Compare each accepted output word with the oldest prediction.
  always @(posedge clk_i) begin
    window_t want;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_windows.size() == 0) begin
        report("unexpected output word", 1, 0);
      end else begin
        want = expected_windows.pop_front();
        if (found_i !== want.found) report("found", found_i, want.found);
        if (best_start_i !== want.start) report("best_start", best_start_i, want.start);
        if (best_length_i !== want.len) report("best_length", best_length_i, want.len);
        if (overflow_i !== want.ovf) report("overflow", overflow_i, want.ovf);
      end
      res_cnt++;
    end
  end

endmodule

`default_nettype wire

[dv/tb_minimum_covering_window_unit.sv]
// Testbench top of the minimum covering window unit: stimulus and verdict.
`default_nettype none

module tb_minimum_covering_window_unit;
  import mcw_pkg::*;

  localparam logic [1:0] CmdIdle = 2'd3;
  localparam int CycleLimit = 2_000_000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      command_i = CmdIdle;
  logic [7:0]      symbol_i = 8'd0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            found_o;
  logic [PosW-1:0] best_start_o;
  logic [LenW-1:0] best_length_o;
  logic            overflow_o;
  int              errors;
  int              pending;
  int              results;
  int              cycles = 0;
  int              words_sent = 0;
  bit              hold_off = 1'b0;

  minimum_covering_window_unit dut (.*);

  mcw_window_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .symbol_i,
    .out_valid_i(out_valid_o), .out_stall_i, .found_i(found_o),
    .best_start_i(best_start_o), .best_length_i(best_length_o),
    .overflow_i(overflow_o), .errors_o(errors), .pending_o(pending),
    .results_o(results)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_minimum_covering_window_unit: done, errors");
      $finish;
    end
  end

  // Receiver stall pattern, with one long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (cycles % 3000 < 1000) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    wait (words_sent >= 300);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Offer one word and hold it until accepted; random gaps between bursts.
  int burst_left = 0;
  task automatic send_word(logic [1:0] cmd, logic [7:0] sym);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    symbol_i   <= sym;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // A target of a few letters from a small set, then source bytes that mostly hit it.
  task automatic random_round();
    int n_target;
    int n_source;
    int span;
    logic [7:0] base;
    base = 8'(FirstSym + $urandom_range(0, SymCount - 6));
    span = $urandom_range(1, 6);
    n_target = $urandom_range(1, 5);
    n_source = $urandom_range(5, 40);
    send_word(CmdClear, 8'($urandom));
    repeat (n_target) send_word(CmdAdd, 8'(base + $urandom_range(0, span - 1)));
    repeat (n_source) begin
      case ($urandom_range(0, 9))
        0: send_word(CmdScan, 8'($urandom));
        1: send_word(CmdIdle, 8'($urandom));
        2: send_word(CmdAdd, 8'(base + $urandom_range(0, span - 1)));
        default: send_word(CmdScan, 8'(base + $urandom_range(0, span)));
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty target, edge bytes, repeated target, mid-scan add.
    send_word(CmdScan, 8'h41);
    send_word(CmdAdd, 8'h40);
    send_word(CmdAdd, 8'h7D);
    send_word(CmdAdd, 8'hFF);
    send_word(CmdAdd, 8'h41);
    send_word(CmdAdd, 8'h7C);
    send_word(CmdAdd, 8'h41);
    send_word(CmdScan, 8'h00);
    send_word(CmdScan, 8'h41);
    send_word(CmdScan, 8'h7C);
    send_word(CmdScan, 8'h41);
    send_word(CmdIdle, 8'hAA);
    send_word(CmdScan, 8'h41);
    send_word(CmdAdd, 8'h42);
    send_word(CmdScan, 8'h7C);
    send_word(CmdScan, 8'h42);
    send_word(CmdScan, 8'h41);
    send_word(CmdScan, 8'h7F);
    send_word(CmdClear, 8'h55);
    send_word(CmdScan, 8'h41);

    // Random rounds.
    while (words_sent < 1550) random_round();
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d input words and %0d output words: edge bytes, mid-scan adds,",
             words_sent, results);
    $display("a long receiver hold-off and random target rounds.");
    if (errors == 0) $display("tb_minimum_covering_window_unit: done, clean");
    else $display("tb_minimum_covering_window_unit: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
